@@ rtl/vdi_pkg.sv @@
package vdi_pkg;

	// Vertex layout: eight raw 32-bit words, pos_x in word 0 up to tex_v in word 7
	localparam int WORDS_PER_VERTEX = 8;
	localparam int WORD_W           = 32;
	localparam int VERTEX_W         = WORDS_PER_VERTEX * WORD_W;
	localparam int INDEX_OUT_W      = 8;

	typedef logic [WORDS_PER_VERTEX-1:0][WORD_W-1:0] vertex_t;

	// Probe status handed from cell to cell
	typedef struct packed {
		logic active;   // a probe occupies this stage
		logic hit;      // an earlier cell already matched
	} probe_t;

endpackage

@@ rtl/vdi_cell.sv @@
module vdi_cell #(
	parameter int DEPTH = 256,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vdi_pkg::vertex_t           query,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_slot,
	input  vdi_pkg::probe_t            probe_in,
	input  logic [$clog2(DEPTH)-1:0]   idx_in,
	output vdi_pkg::probe_t            probe_out,
	output logic [$clog2(DEPTH)-1:0]   idx_out
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [IW-1:0] SLOT_C  = IW'(IDX);
	localparam logic [CW-1:0] SLOT_CW = CW'(IDX);

	vdi_pkg::vertex_t entry_q;
	vdi_pkg::probe_t  probe_q;
	logic [IW-1:0]    idx_q;
	logic             live;
	logic             match;

	// This slot holds a vertex of the current mesh only below the fill count
	assign live  = count > SLOT_CW;
	assign match = probe_in.active && !probe_in.hit && live && (entry_q == query);

	// Entry storage, written once per append
	always_ff @(posedge clk) begin
		if (wr_en && (wr_slot == SLOT_C)) begin
			entry_q <= query;
		end
	end

	// Probe stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.active <= probe_in.active;
			probe_q.hit    <= probe_in.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= match ? SLOT_C : idx_in;
	end

	assign probe_out = probe_q;
	assign idx_out   = idx_q;

endmodule

@@ rtl/vertex_dedup_indexer_top.sv @@
// Flow: a transfer registers the query, the probe launch register then starts the probe,
// it walks the cell chain one cell per cycle, the chain tail is captured into the result
//   registers, and the commit writes the output register once that register is free.
// A new vertex is taken only once the last one has committed, even while its result still waits in the output register.
// Reset (arst_n low, asynchronous): empty table, idle, no output pending.
module vertex_dedup_indexer_top #(
	parameter int DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
	input  logic         s_tuser,   // start_mesh
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // vertex_index
	output logic [1:0]   m_tuser    // is_new, overflow
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	vdi_pkg::vertex_t query_q;
	logic [CW-1:0]    count_q;
	logic             probe_go_q;
	logic             res_hit_q;
	logic [IW-1:0]    res_idx_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic             accept;
	logic             commit;
	logic             full;
	logic             wr_en;
	logic [IW-1:0]    wr_slot;
	logic [IW-1:0]    sel_idx;
	logic [IW+7:0]    idx_ext;

	vdi_pkg::probe_t  probe_w [DEPTH+1];
	logic [IW-1:0]    idx_w   [DEPTH+1];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign full     = count_q >= CW'(DEPTH);
	assign wr_en    = commit && !res_hit_q && !full;
	assign wr_slot  = count_q[IW-1:0];

	// Probe launch in the cycle after the transfer, once query and count are settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_go_q <= 1'b0;
		end else begin
			probe_go_q <= accept;
		end
	end

	// Probe injection at the head of the chain
	assign probe_w[0].active = probe_go_q;
	assign probe_w[0].hit    = 1'b0;
	assign idx_w[0]          = '0;

	// Compare chain, one slot per cell
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		vdi_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.query     (query_q),
			.count     (count_q),
			.wr_en     (wr_en),
			.wr_slot   (wr_slot),
			.probe_in  (probe_w[i]),
			.idx_in    (idx_w[i]),
			.probe_out (probe_w[i+1]),
			.idx_out   (idx_w[i+1])
		);
	end

	// Index shown downstream: match slot or the append slot, low 8 bits
	assign sel_idx = res_hit_q ? res_idx_q : wr_slot;
	assign idx_ext = {8'b0, sel_idx};

	// Sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						if (s_tuser) begin
							count_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (probe_w[DEPTH].active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query and chain-tail capture
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= s_tdata;
		end
		if ((state_q == ST_SCAN) && probe_w[DEPTH].active) begin
			res_hit_q <= probe_w[DEPTH].hit;
			res_idx_q <= idx_w[DEPTH];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			priority if (res_hit_q) begin
				m_tdata_q <= idx_ext[7:0];
				m_tuser_q <= 2'b00;
			end else if (full) begin
				m_tdata_q <= '0;
				m_tuser_q <= 2'b10;
			end else begin
				m_tdata_q <= idx_ext[7:0];
				m_tuser_q <= 2'b01;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/vdi_checker.sv @@
module vdi_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata,
	input logic [1:0]   m_tuser
);

	// A stalled result transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One vertex in flight: input closes right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second vertex taken during a scan");

	// A result is either a match, an append or an overflow
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("is_new and overflow both set");

	// Overflow reports index zero
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 8'd0))
		else $error("overflow with nonzero index");

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH      = 256;
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam int INDEX_OUT_W      = vdi_pkg::INDEX_OUT_W;
	localparam int VERTEX_W         = vdi_pkg::VERTEX_W;
	localparam int WORDS_PER_VERTEX = vdi_pkg::WORDS_PER_VERTEX;

	// One expected lookup result
	typedef struct packed {
		logic [INDEX_OUT_W-1:0] vtx_index;
		logic                   is_new;
		logic                   overflow;
	} lookup_result_t;

	logic                      clk;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [VERTEX_W-1:0]       s_tdata  = '0;
	logic                      s_tuser  = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [INDEX_OUT_W-1:0]    m_tdata;
	logic [1:0]                m_tuser;

	// Predictor state: unique vertices of the current mesh
	vdi_pkg::vertex_t          mesh_table [DEPTH];
	int unsigned               mesh_count = 0;

	lookup_result_t            pending_lookups [$];
	int                        mismatch_count = 0;
	int                        cycle_count    = 0;
	bit                        idle_on        = 1'b0;
	int                        stall_left     = 0;

	vertex_dedup_indexer_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bitwise table lookup; appends on a miss unless the table is full
	function automatic lookup_result_t dedup_lookup(input logic start,
		input vdi_pkg::vertex_t vtx);
		lookup_result_t res;
		int             slot;
		res = '0;
		if (start)
			mesh_count = 0;
		for (slot = 0; slot < mesh_count; slot++) begin
			if (mesh_table[slot] == vtx) begin
				res.vtx_index = INDEX_OUT_W'(slot);
				return res;
			end
		end
		if (mesh_count >= DEPTH) begin
			res.overflow = 1'b1;
			return res;
		end
		mesh_table[mesh_count] = vtx;
		res.vtx_index = INDEX_OUT_W'(mesh_count);
		res.is_new    = 1'b1;
		mesh_count++;
		return res;
	endfunction

	// Random vertex; some words take signed zeros, all ones or NaN patterns
	function automatic vdi_pkg::vertex_t random_vertex();
		vdi_pkg::vertex_t vtx;
		for (int w = 0; w < WORDS_PER_VERTEX; w++) begin
			case ($urandom_range(0, 11))
				0:       vtx[w] = 32'h0000_0000;
				1:       vtx[w] = 32'hFFFF_FFFF;
				2:       vtx[w] = 32'h8000_0000;
				3:       vtx[w] = 32'h7FC0_0000;
				default: vtx[w] = $urandom();
			endcase
		end
		return vtx;
	endfunction

	// Drive one vertex and wait for its transfer; valid stays high until an idle gap or release_input lowers it
	task automatic send_vertex(input logic start, input vdi_pkg::vertex_t vtx);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= vtx;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_lookups.push_back(dedup_lookup(start, vtx));
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Hits, misses, signed zeros, NaN patterns, single-bit differences, mesh restart
	task automatic test_directed();
		vdi_pkg::vertex_t zero_v, ones_v, negz_v, nan_v, near_v;
		zero_v = '0;
		ones_v = '1;
		negz_v = '0;
		negz_v[0] = 32'h8000_0000;
		nan_v = {WORDS_PER_VERTEX{32'h7FC0_0001}};
		idle_on = 1'b1;
		send_vertex(1'b1, zero_v);
		send_vertex(1'b0, ones_v);
		send_vertex(1'b0, zero_v);
		send_vertex(1'b0, ones_v);
		send_vertex(1'b0, negz_v);
		send_vertex(1'b0, nan_v);
		send_vertex(1'b0, nan_v);
		near_v = '0;
		near_v[7][31] = 1'b1;
		send_vertex(1'b0, near_v);
		near_v = '0;
		near_v[0][0] = 1'b1;
		send_vertex(1'b0, near_v);
		send_vertex(1'b0, negz_v);
		// restart: the same vertex lands at slot zero again
		send_vertex(1'b1, ones_v);
		send_vertex(1'b0, zero_v);
		send_vertex(1'b1, ones_v);
		send_vertex(1'b0, ones_v);
	endtask

	// Fill every slot, then probe misses and hits on the full table
	task automatic test_table_full();
		vdi_pkg::vertex_t first_v, last_v, vtx;
		idle_on = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			vtx = random_vertex();
			vtx[0] = 32'(i);
			if (i == 0)
				first_v = vtx;
			last_v = vtx;
			send_vertex(i == 0, vtx);
		end
		vtx = random_vertex();
		vtx[0] = 32'hFFFF_FFFF;
		send_vertex(1'b0, vtx);
		send_vertex(1'b0, last_v);
		send_vertex(1'b0, first_v);
		send_vertex(1'b0, vtx);
		send_vertex(1'b1, vtx);
	endtask

	// Meshes with repeated, near-miss and fresh vertices; a few stray restarts
	task automatic test_random_meshes(input int n_items, input bit allow_idle);
		vdi_pkg::vertex_t seen_q [$];
		vdi_pkg::vertex_t vtx;
		logic    start;
		int      sent, mesh_len, pick;
		sent = 0;
		while (sent < n_items) begin
			idle_on  = allow_idle && ($urandom_range(0, 3) != 0);
			mesh_len = $urandom_range(1, 60);
			seen_q.delete();
			for (int k = 0; k < mesh_len && sent < n_items; k++) begin
				pick = $urandom_range(0, 19);
				if (seen_q.size() == 0 || pick < 7) begin
					vtx = random_vertex();
				end else if (pick < 16) begin
					vtx = seen_q[$urandom_range(0, seen_q.size() - 1)];
				end else begin
					vtx = seen_q[$urandom_range(0, seen_q.size() - 1)];
					vtx[$urandom_range(0, 7)][$urandom_range(0, 31)] ^= 1'b1;
				end
				if (k == 0)
					start = ($urandom_range(0, 9) != 0);
				else
					start = ($urandom_range(0, 49) == 0);
				send_vertex(start, vtx);
				seen_q.push_back(vtx);
				sent++;
			end
		end
	endtask

	// Receiver backpressure in short bursts
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready   <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest pending lookup
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result: index %0d tuser %b", $time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (m_tdata !== want.vtx_index) begin
					$display("%0t: vertex_index expected %0d, got %0d",
						$time, want.vtx_index, m_tdata);
					mismatch_count++;
				end
				if (m_tuser[0] !== want.is_new) begin
					$display("%0t: is_new expected %b, got %b", $time, want.is_new, m_tuser[0]);
					mismatch_count++;
				end
				if (m_tuser[1] !== want.overflow) begin
					$display("%0t: overflow expected %b, got %b",
						$time, want.overflow, m_tuser[1]);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL vertex_dedup_indexer_top");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		test_random_meshes(500, 1'b1);
		test_random_meshes(180, 1'b0);

		// no idling while draining
		idle_on = 1'b0;
		release_input();
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_lookups.size() == 0)
			$display("PASS vertex_dedup_indexer_top");
		else
			$display("FAIL vertex_dedup_indexer_top");
		$finish;
	end

endmodule

@@ files.f @@
rtl/vdi_pkg.sv
rtl/vdi_cell.sv
rtl/vertex_dedup_indexer_top.sv
rtl/vdi_checker.sv
sim/tb_top.sv
